@@ src/rkl_pkg.sv @@
// Shared types and sizes for the running k-th largest tracker.
// Used by rkl_heap_ram and running_kth_largest; depends on nothing else.
`timescale 1ns / 1ps

package rkl_pkg;

    // Heap capacity and derived widths.
    localparam int HEAP_DEPTH = 64;
    localparam int AW         = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW         = $clog2(HEAP_DEPTH + 1);
    localparam int CIW        = AW + 2;
    localparam int VW         = 32;
    localparam int RW         = 7;

    typedef logic signed [VW-1:0] value_t;
    typedef logic [AW-1:0]        addr_t;
    typedef logic [CW-1:0]        count_t;

    // Write request toward the heap memory.
    typedef struct packed {
        logic   en;
        addr_t  addr;
        value_t data;
    } wr_req_t;

    // Read addresses toward the heap memory, one per read port.
    typedef struct packed {
        addr_t addr_a;
        addr_t addr_b;
    } rd_req_t;

endpackage

@@ src/running_kth_largest.sv @@
// Top level of the running k-th largest tracker: request handshakes, the
// heap sequencer and the result register. Depends on rkl_pkg and rkl_heap_ram.
//
//   channel   signals                             direction  contents
//   input     in_valid, in_ready, new_value       in         one stream value
//   output    out_valid, out_ready, kth_value,    out        heap minimum and
//             rank_reached                                   full flag
//   config    cfg_wr_en, cfg_wr_data              in         rank k, clears heap
//
// A dropped request goes from idle straight to the final state, and its result
// is registered as it leaves that state. An insert or a replace moves the hole
// one heap level per read state and compare state before the final state. In
// every case the next request can be accepted in the same cycle that the result
// appears. Each level needs one registered memory read and one write through the
// single write port.
// Reset clears the count and sets the rank to 1; heap memory is not cleared.
// The block takes one request at a time; a result that waits on out_ready
// holds the sequencer in its final state.
`timescale 1ns / 1ps

module running_kth_largest (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [31:0]      new_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [31:0]      kth_value,
    output logic                    rank_reached,
    input  logic                    cfg_wr_en,
    input  logic [rkl_pkg::RW-1:0]  cfg_wr_data
);
    import rkl_pkg::*;

    // Sequencer state codes.
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UP_RD  = 3'd1;
    localparam logic [2:0] ST_UP_CMP = 3'd2;
    localparam logic [2:0] ST_DN_RD  = 3'd3;
    localparam logic [2:0] ST_DN_CMP = 3'd4;
    localparam logic [2:0] ST_FIN    = 3'd5;

    logic [2:0]       state_reg, state_next;
    count_t           count_reg, count_next;
    count_t           eff_k_reg;
    addr_t            pos_reg, pos_next;
    value_t           val_reg, val_next;
    value_t           root_reg;
    logic             out_valid_reg;
    value_t           kth_value_reg;
    logic             rank_reached_reg;

    wr_req_t          wr;
    rd_req_t          rd;
    value_t           rd_data_a;
    value_t           rd_data_b;

    logic [CIW-1:0]   left_idx;
    logic [CIW-1:0]   right_idx;
    logic [CIW-1:0]   count_ext;
    addr_t            parent_addr;
    logic             left_lt;
    logic             right_ok;
    logic             right_lt;
    logic             out_free;
    count_t           rank_clamped;

    rkl_heap_ram u_ram (
        .clk       (clk),
        .wr        (wr),
        .rd        (rd),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    // Rank written to the configuration port, held to 1..HEAP_DEPTH.
    always_comb
    begin
        if (cfg_wr_data == '0)
        begin
            rank_clamped = CW'(1);
        end
        else if (32'(cfg_wr_data) > 32'(HEAP_DEPTH))
        begin
            rank_clamped = CW'(HEAP_DEPTH);
        end
        else
        begin
            rank_clamped = CW'(cfg_wr_data);
        end
    end

    // Heap index arithmetic around the current hole.
    assign left_idx    = {1'b0, pos_reg, 1'b1};
    assign right_idx   = left_idx + CIW'(1);
    assign count_ext   = CIW'(count_reg);
    assign parent_addr = (pos_reg - AW'(1)) >> 1;

    // Child compares for the downward pass; the left child exists in ST_DN_CMP.
    assign left_lt  = rd_data_a < val_reg;
    assign right_ok = right_idx < count_ext;
    assign right_lt = right_ok && (rd_data_b < (left_lt ? rd_data_a : val_reg));

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);

    // Sequencer: the hole moves up or down one level per read and compare.
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        wr.en      = 1'b0;
        wr.addr    = pos_reg;
        wr.data    = val_reg;
        rd.addr_a  = parent_addr;
        rd.addr_b  = right_idx[AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    val_next = new_value;
                    if (count_reg < eff_k_reg)
                    begin
                        pos_next   = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                        state_next = ST_UP_RD;
                    end
                    else if (root_reg < new_value)
                    begin
                        pos_next   = '0;
                        state_next = ST_DN_RD;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end

            ST_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    wr.en      = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_UP_CMP;
                end
            end

            ST_UP_CMP:
            begin
                wr.en = 1'b1;
                if (val_reg < rd_data_a)
                begin
                    wr.data    = rd_data_a;
                    pos_next   = parent_addr;
                    state_next = ST_UP_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_DN_RD:
            begin
                rd.addr_a = left_idx[AW-1:0];
                if (left_idx < count_ext)
                begin
                    state_next = ST_DN_CMP;
                end
                else
                begin
                    wr.en      = 1'b1;
                    state_next = ST_FIN;
                end
            end

            ST_DN_CMP:
            begin
                rd.addr_a = left_idx[AW-1:0];
                wr.en     = 1'b1;
                if (right_lt)
                begin
                    wr.data    = rd_data_b;
                    pos_next   = right_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end
                else if (left_lt)
                begin
                    wr.data    = rd_data_a;
                    pos_next   = left_idx[AW-1:0];
                    state_next = ST_DN_RD;
                end
                else
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers; a rank write empties the heap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            eff_k_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                eff_k_reg <= rank_clamped;
                count_reg <= '0;
            end
            else
            begin
                count_reg <= count_next;
            end
            if (state_reg == ST_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hole position, moving value, root copy, result.
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        val_reg <= val_next;
        if (wr.en && wr.addr == '0)
        begin
            root_reg <= wr.data;
        end
        if (state_reg == ST_FIN && out_free)
        begin
            kth_value_reg    <= root_reg;
            rank_reached_reg <= (count_reg >= eff_k_reg);
        end
    end

    assign out_valid    = out_valid_reg;
    assign kth_value    = kth_value_reg;
    assign rank_reached = rank_reached_reg;

    // The heap never holds more entries than the rank.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= eff_k_reg)
        else $error("held count exceeds rank");

    // Memory writes only happen while a request is being worked.
    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> state_reg != ST_IDLE)
        else $error("heap write while idle");

    // The downward pass only runs on a full heap.
    a_down_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DN_RD || state_reg == ST_DN_CMP) |-> count_reg == eff_k_reg)
        else $error("replace pass on a heap that is not full");

    // An accepted request blocks the next one until it is done.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second request taken while busy");

endmodule

@@ src/rkl_heap_ram.sv @@
// Heap storage: one write port and two read ports with registered read data.
// Depends on rkl_pkg for widths and the request structs.
`timescale 1ns / 1ps

module rkl_heap_ram (
    input  logic             clk,
    input  rkl_pkg::wr_req_t wr,
    input  rkl_pkg::rd_req_t rd,
    output rkl_pkg::value_t  rd_data_a,
    output rkl_pkg::value_t  rd_data_b
);
    import rkl_pkg::*;

    value_t mem [HEAP_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd.addr_a];
        rd_data_b <= mem[rd.addr_b];
    end

endmodule

@@ tb/rkl_result_checker.sv @@
// Checker for the running k-th largest tracker: watches the request channels,
// keeps its own heap of the k largest values and compares every result.
// Depends on rkl_pkg for the value type, the heap depth and the rank width.
`timescale 1ns / 1ps

module rkl_result_checker (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  rkl_pkg::value_t         new_value,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  rkl_pkg::value_t         kth_value,
    input  logic                    rank_reached,
    input  logic                    cfg_wr_en,
    input  logic [rkl_pkg::RW-1:0]  cfg_wr_data,
    output int                      error_count,
    output int                      pending_results
);
    import rkl_pkg::*;

    // One predicted result: the heap minimum and the full flag.
    typedef struct packed {
        value_t kth;
        logic   full;
    } kth_result_t;

    // Predicted heap of the largest values seen since the last rank write.
    value_t         top_values [HEAP_DEPTH];
    int             top_count;
    logic [RW-1:0]  rank_setting;
    kth_result_t    expected_q [$];

    // Rank in force: zero acts as one and anything above the depth is clipped.
    function automatic int active_rank();
        int k;
        k = rank_setting;
        if (k < 1)
        begin
            k = 1;
        end
        if (k > HEAP_DEPTH)
        begin
            k = HEAP_DEPTH;
        end
        return k;
    endfunction

    // Folds one stream value into the predicted heap and returns the result it gives.
    function automatic kth_result_t track_value(input value_t v);
        int          k;
        int          pos;
        int          parent;
        int          left;
        int          best;
        bit          settled;
        value_t      swap_val;
        kth_result_t res;
        k = active_rank();
        if (top_count < k)
        begin
            // Not yet full: append and sift toward the root.
            top_values[top_count] = v;
            pos = top_count;
            top_count++;
            settled = 1'b0;
            while (pos > 0 && !settled)
            begin
                parent = (pos - 1) / 2;
                if (top_values[pos] < top_values[parent])
                begin
                    swap_val = top_values[pos];
                    top_values[pos] = top_values[parent];
                    top_values[parent] = swap_val;
                    pos = parent;
                end
                else
                begin
                    settled = 1'b1;
                end
            end
        end
        else if (top_values[0] < v)
        begin
            // Full and larger than the minimum: replace the root and sift down.
            top_values[0] = v;
            pos = 0;
            settled = 1'b0;
            while (!settled)
            begin
                left = 2 * pos + 1;
                best = pos;
                if (left < top_count && top_values[left] < top_values[best])
                begin
                    best = left;
                end
                if (left + 1 < top_count && top_values[left + 1] < top_values[best])
                begin
                    best = left + 1;
                end
                if (best == pos)
                begin
                    settled = 1'b1;
                end
                else
                begin
                    swap_val = top_values[pos];
                    top_values[pos] = top_values[best];
                    top_values[best] = swap_val;
                    pos = best;
                end
            end
        end
        res.kth  = top_values[0];
        res.full = (top_count >= k);
        return res;
    endfunction

    // Rank writes, result comparison and prediction, all at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin
        kth_result_t want;
        if (!rst_n)
        begin
            top_count       = 0;
            rank_setting    = 1;
            error_count     = 0;
            pending_results = 0;
            expected_q.delete();
        end
        else
        begin
            if (cfg_wr_en)
            begin
                rank_setting = cfg_wr_data;
                top_count    = 0;
            end
            // The result is checked before a new request is predicted.
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no request waiting: kth_value %0d, rank_reached %0b",
                           kth_value, rank_reached);
                    error_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (kth_value !== want.kth)
                    begin
                        $error("kth_value: expected %0d, got %0d", want.kth, kth_value);
                        error_count++;
                    end
                    if (rank_reached !== want.full)
                    begin
                        $error("rank_reached: expected %0b, got %0b", want.full, rank_reached);
                        error_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_q.insert(expected_q.size(), track_value(new_value));
            end
            pending_results = expected_q.size();
        end
    end

endmodule

@@ tb/running_kth_largest_tb.sv @@
// Testbench top for the running k-th largest tracker: clock, reset, stimulus
// and verdict. Depends on rkl_pkg, running_kth_largest and rkl_result_checker.
`timescale 1ns / 1ps

module running_kth_largest_tb;
    import rkl_pkg::*;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready;
    value_t         new_value = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    value_t         kth_value;
    logic           rank_reached;
    logic           cfg_wr_en = 1'b0;
    logic [RW-1:0]  cfg_wr_data = '0;

    int             error_count;
    int             pending_results;
    int             sent_count = 0;
    int             results_seen = 0;
    bit             hold_done = 1'b0;

    // Ranks for the random phases; zero and values above the depth included.
    int             phase_ranks [14] = '{0, 2, 64, 5, 127, 1, 16, 63, 7, 65, 31, 3, 100, 8};

    running_kth_largest DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .new_value    (new_value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kth_value    (kth_value),
        .rank_reached (rank_reached),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    rkl_result_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .new_value       (new_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .kth_value       (kth_value),
        .rank_reached    (rank_reached),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // 2 ns clock.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Count accepted results; the receiver uses it to place its hold-off.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            results_seen <= results_seen + 1;
        end
    end

    // Receiver: random stalls, one long hold-off, and a stretch with no stalls.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!hold_done && results_seen >= 300)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (250) @(posedge clk);
            end
            else if (results_seen >= 600 && results_seen < 800)
            begin
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Offers one request and returns at the edge where it is accepted.
    task automatic send_value(input value_t v);
        if (!(sent_count >= 600 && sent_count < 800) && $urandom_range(99) < 15)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        new_value <= v;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        sent_count++;
    endtask

    // Lowers valid and waits until every predicted result has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0)
        begin
            @(negedge clk);
        end
        @(posedge clk);
    endtask

    // Writes the rank register while the block is idle.
    task automatic write_rank(input int k);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= RW'(k);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Random stream value: full range, a narrow band for ties, or near the extremes.
    function automatic value_t random_value();
        value_t v;
        case ($urandom_range(9))
            4, 5, 6: v = value_t'(int'($urandom_range(16)) - 8);
            7:       v = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            8:       v = 32'h7FFF_FFFF - $urandom_range(3);
            9:       v = 32'h8000_0000 + $urandom_range(3);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Stimulus and verdict.
    initial
    begin
        int eff;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Start-up list at the reset rank of one, with extremes and repeats of the minimum.
        send_value(5);
        send_value(-3);
        send_value(12);
        send_value(12);
        send_value(32'h7FFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(0);
        send_value(-1);

        // Rank three: fill with the most negative value, then climb to the top.
        write_rank(3);
        send_value(32'h8000_0000);
        send_value(32'h8000_0000);
        send_value(32'h8000_0000);
        send_value(32'h8000_0000);
        send_value(-1);
        send_value(0);
        send_value(32'h7FFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(32'h7FFF_FFFF);
        send_value(1);
        send_value(32'h7FFF_FFFE);

        // Random phases over a spread of ranks.
        foreach (phase_ranks[p])
        begin
            write_rank(phase_ranks[p]);
            eff = phase_ranks[p];
            if (eff < 1)
            begin
                eff = 1;
            end
            if (eff > HEAP_DEPTH)
            begin
                eff = HEAP_DEPTH;
            end
            n = 30 + 2 * eff;
            repeat (n)
            begin
                send_value(random_value());
            end
        end

        drain_results();
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog.
    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
